FILE: sv/ibrs_pkg.sv
// ----------------------------------------------------------------------------
// ibrs_pkg: shared types and constants of the I2C burst read sequencer
// Holds the phase encoding, bus command codes, register indexes and the
// item and result structures that travel between the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ibrs_pkg;

  // Number of bytes read in one burst (2..64)
  localparam int BURST_BYTES = 14;
  localparam int CNT_W       = 6;
  localparam int WIDX_W      = 5;

  localparam logic [7:0] WADDR_RST = 8'd208;
  localparam logic [7:0] RADDR_RST = 8'd209;
  localparam logic [7:0] FIRST_RST = 8'd59;

  typedef enum logic [8:0] {
    PH_READY   = 9'b000000001,
    PH_START   = 9'b000000010,
    PH_ADDRW   = 9'b000000100,
    PH_REG     = 9'b000001000,
    PH_RESTART = 9'b000010000,
    PH_ADDRR   = 9'b000100000,
    PH_RCV     = 9'b001000000,
    PH_ACK     = 9'b010000000,
    PH_STOP    = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_TX      = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_RX      = 3'd4,
    CMD_ACKBIT  = 3'd5,
    CMD_STOP    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_WADDR = 2'd0,
    CFG_RADDR = 2'd1,
    CFG_FIRST = 2'd2
  } cfg_idx_t;

  localparam logic MODE_START = 1'b0;

  typedef struct packed {
    logic [7:0] waddr;
    logic [7:0] raddr;
    logic [7:0] first_reg;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic       ack_received;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    cmd_t              bus_command;
    logic [7:0]        tx_byte;
    logic              ack_level;
    logic              word_valid;
    logic [WIDX_W-1:0] word_index;
    logic [15:0]       word_value;
    logic              burst_done;
    logic              aborted;
    logic              idle;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/ibrs_cfg_regs.sv
// ----------------------------------------------------------------------------
// ibrs_cfg_regs: configuration register file
// Holds the device address bytes and the first register pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module ibrs_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output ibrs_pkg::cfg_t         cfg
);
  import ibrs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WADDR: cfg_nxt.waddr     = cfg_data;
        CFG_RADDR: cfg_nxt.raddr     = cfg_data;
        CFG_FIRST: cfg_nxt.first_reg = cfg_data;
        default:   cfg_nxt           = cfg_r;  // unused index: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waddr     <= WADDR_RST;
      cfg_r.raddr     <= RADDR_RST;
      cfg_r.first_reg <= FIRST_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ibrs_seq.sv
// ----------------------------------------------------------------------------
// ibrs_seq: phase sequencer and word assembler
// Computes the result of one item from the held phase, byte count and high
// byte, and advances that state when the item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ibrs_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire ibrs_pkg::in_item_t item,
  input  wire ibrs_pkg::cfg_t     cfg,
  output ibrs_pkg::result_t       res
);
  import ibrs_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [CNT_W:0]   cnt_inc;

  assign cnt_inc = {1'b0, cnt_r} + (CNT_W+1)'(1);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    res       = '0;
    res.bus_command = CMD_NONE;

    if (item.mode == MODE_START) begin
      if (phase_r == PH_READY) begin
        cnt_nxt         = '0;
        held_nxt        = '0;
        phase_nxt       = PH_START;
        res.bus_command = CMD_START;
      end
    end else begin
      unique case (phase_r)
        PH_READY: begin
          phase_nxt = PH_READY;
        end
        PH_START: begin
          res.bus_command = CMD_TX;
          res.tx_byte     = cfg.waddr;
          phase_nxt       = PH_ADDRW;
        end
        PH_ADDRW: begin
          if (item.ack_received) begin
            res.bus_command = CMD_TX;
            res.tx_byte     = cfg.first_reg;
            phase_nxt       = PH_REG;
          end else begin
            res.bus_command = CMD_STOP;
            res.aborted     = 1'b1;
            phase_nxt       = PH_STOP;
          end
        end
        PH_REG: begin
          if (item.ack_received) begin
            res.bus_command = CMD_RESTART;
            phase_nxt       = PH_RESTART;
          end else begin
            res.bus_command = CMD_STOP;
            res.aborted     = 1'b1;
            phase_nxt       = PH_STOP;
          end
        end
        PH_RESTART: begin
          res.bus_command = CMD_TX;
          res.tx_byte     = cfg.raddr;
          phase_nxt       = PH_ADDRR;
        end
        PH_ADDRR: begin
          if (item.ack_received) begin
            res.bus_command = CMD_RX;
            phase_nxt       = PH_RCV;
          end else begin
            res.bus_command = CMD_STOP;
            res.aborted     = 1'b1;
            phase_nxt       = PH_STOP;
          end
        end
        PH_RCV: begin
          // even byte is the high half, odd byte completes a word
          if (!cnt_r[0]) begin
            held_nxt = item.rx_byte;
          end else begin
            res.word_valid = 1'b1;
            res.word_index = cnt_r[CNT_W-1:1];
            res.word_value = {held_r, item.rx_byte};
          end
          if (cnt_inc >= (CNT_W+1)'(BURST_BYTES)) begin
            res.ack_level  = 1'b1;
            res.burst_done = 1'b1;
          end
          cnt_nxt         = cnt_inc[CNT_W-1:0];
          res.bus_command = CMD_ACKBIT;
          phase_nxt       = PH_ACK;
        end
        PH_ACK: begin
          // a wrapped count of zero also ends the burst
          if ((cnt_r != '0) && ({1'b0, cnt_r} < (CNT_W+1)'(BURST_BYTES))) begin
            res.bus_command = CMD_RX;
            phase_nxt       = PH_RCV;
          end else begin
            res.bus_command = CMD_STOP;
            phase_nxt       = PH_STOP;
          end
        end
        PH_STOP: begin
          phase_nxt = PH_READY;
        end
        default: begin
          phase_nxt = PH_READY;
        end
      endcase
    end

    res.idle = (phase_nxt == PH_READY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_READY;
      cnt_r   <= '0;
      held_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/i2c_burst_read_sequencer_unit.sv
// An accepted item passes the input register, then the result register, before
//   its result can be taken on out_.
// Throughput: one item per cycle unless out_ stalls; the state updates in one step.
// Reset (rst_n low, synchronous): both stages empty, phase ready, byte count
//   and high byte cleared, configuration registers back to 208, 209 and 59.
// ----------------------------------------------------------------------------
// i2c_burst_read_sequencer_unit: top level of the I2C burst read sequencer
// Registers each item, steps the sequencer and holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_burst_read_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [0] ack_received, [8:1] rx_byte, rest zero
  input  wire logic [0:0]  in_tuser,   // [0] mode
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [2:0] bus_command, [10:3] tx_byte,
                                       // [11] ack_level, [12] word_valid,
                                       // [17:13] word_index, [33:18] word_value,
                                       // [34] aborted, [35] idle, rest zero
  output logic             out_tlast,  // burst_done
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import ibrs_pkg::*;

  cfg_t     cfg;
  in_item_t s1_item_r;
  logic     s1_valid_r, s1_valid_nxt;
  result_t  res;
  result_t  out_res_r;
  logic     out_valid_r, out_valid_nxt;
  logic     out_free;
  logic     s1_move;
  logic     in_fire;

  ibrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the input stage whenever the result register is empty or drains
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Step the state only when the registered item moves into the result stage
  ibrs_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_move),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode         <= in_tuser[0];
      s1_item_r.ack_received <= in_tdata[0];
      s1_item_r.rx_byte      <= in_tdata[8:1];
    end
    if (s1_move) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.burst_done;
  assign out_tdata  = {4'b0000,
                       out_res_r.idle,
                       out_res_r.aborted,
                       out_res_r.word_value,
                       out_res_r.word_index,
                       out_res_r.word_valid,
                       out_res_r.ack_level,
                       out_res_r.tx_byte,
                       out_res_r.bus_command};

endmodule

`default_nettype wire

FILE: sv/ibrs_checker.sv
// ----------------------------------------------------------------------------
// ibrs_checker: port-level checks of the I2C burst read sequencer
// Watches the result channel for consistent command and status fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ibrs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast
);
  import ibrs_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // An abort always issues a stop and never lands in ready
  a_abort_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> out_tdata[2:0] == CMD_STOP && !out_tdata[35])
    else $error("abort without stop");

  // Words only come with an ack bit command
  a_word_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[2:0] == CMD_ACKBIT)
    else $error("word outside ack bit command");

  // The last byte of a burst is answered with a nack
  a_last_nack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[11] && out_tdata[2:0] == CMD_ACKBIT)
    else $error("burst end without nack");

endmodule

bind i2c_burst_read_sequencer_unit ibrs_checker u_ibrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

FILE: test/tb_i2c_burst_read_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_i2c_burst_read_sequencer_unit: regression bench of the burst read sequencer
// Feeds start requests and bus completion events through the in_ stream,
// steps a local copy of the sequencer for every item taken, and checks each
// result on the out_ stream field by field. Covers all three address NACK
// aborts, full bursts with random data, stray requests, and several
// configurations under random and forced back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_i2c_burst_read_sequencer_unit;
  import ibrs_pkg::*;

  localparam logic MODE_EVENT = 1'b1;
  // Cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // Length of the forced receiver hold-off
  localparam int LONG_HOLD = 300;
  // Cycles left after the last result, well past the two-stage latency
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;  // [0] ack_received, [8:1] rx_byte, rest zero
  logic [0:0]  in_tuser = '0;  // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;      // [2:0] bus_command, [10:3] tx_byte, [11] ack_level,
                               // [12] word_valid, [17:13] word_index,
                               // [33:18] word_value, [34] aborted, [35] idle
  logic        out_tlast;      // burst_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  i2c_burst_read_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Bus items waiting for the driver, and bus steps waiting for the monitor
  in_item_t sequencer_items[$];
  result_t  expected_steps[$];
  int       issued_count = 0;
  int       accepted_count = 0;
  int       mismatches = 0;

  // Idle rates in percent, changed per phase by the stimulus
  int send_idle_pct = 29;
  int recv_idle_pct = 76;
  // Bumped by the stimulus to ask the receiver for one long hold-off
  int hold_req = 0;

  // Local copy of the configuration registers
  logic [7:0] cfg_waddr = WADDR_RST;
  logic [7:0] cfg_raddr = RADDR_RST;
  logic [7:0] cfg_first = FIRST_RST;

  // Local copy of the sequencer state
  phase_t     seq_ph = PH_READY;
  logic [5:0] byte_count = '0;
  logic [7:0] high_byte = '0;

  // Advance the local sequencer by one item and return the bus step it causes.
  function automatic result_t next_bus_step(in_item_t it);
    result_t r;
    logic    nack;
    r = '0;
    r.bus_command = CMD_NONE;
    nack = 1'b0;
    if (it.mode == MODE_START) begin
      // a start only counts while ready; otherwise it is dropped
      if (seq_ph == PH_READY) begin
        byte_count = '0;
        high_byte = '0;
        seq_ph = PH_START;
        r.bus_command = CMD_START;
      end
    end else begin
      case (seq_ph)
        PH_READY: begin
        end
        PH_START: begin
          r.bus_command = CMD_TX;
          r.tx_byte = cfg_waddr;
          seq_ph = PH_ADDRW;
        end
        PH_ADDRW: begin
          if (it.ack_received) begin
            r.bus_command = CMD_TX;
            r.tx_byte = cfg_first;
            seq_ph = PH_REG;
          end else begin
            nack = 1'b1;
          end
        end
        PH_REG: begin
          if (it.ack_received) begin
            r.bus_command = CMD_RESTART;
            seq_ph = PH_RESTART;
          end else begin
            nack = 1'b1;
          end
        end
        PH_RESTART: begin
          r.bus_command = CMD_TX;
          r.tx_byte = cfg_raddr;
          seq_ph = PH_ADDRR;
        end
        PH_ADDRR: begin
          if (it.ack_received) begin
            r.bus_command = CMD_RX;
            seq_ph = PH_RCV;
          end else begin
            nack = 1'b1;
          end
        end
        PH_RCV: begin
          // even count: hold the high byte; odd count: complete the word
          if (!byte_count[0]) begin
            high_byte = it.rx_byte;
          end else begin
            r.word_valid = 1'b1;
            r.word_index = byte_count[5:1];
            r.word_value = {high_byte, it.rx_byte};
          end
          if (int'(byte_count) + 1 >= BURST_BYTES) begin
            r.ack_level = 1'b1;
            r.burst_done = 1'b1;
          end
          byte_count = byte_count + 6'd1;
          r.bus_command = CMD_ACKBIT;
          seq_ph = PH_ACK;
        end
        PH_ACK: begin
          // a wrapped count of zero also ends the burst
          if (byte_count != 0 && int'(byte_count) < BURST_BYTES) begin
            r.bus_command = CMD_RX;
            seq_ph = PH_RCV;
          end else begin
            r.bus_command = CMD_STOP;
            seq_ph = PH_STOP;
          end
        end
        PH_STOP: begin
        end
        default: seq_ph = PH_READY;
      endcase
      if (nack) begin
        r.bus_command = CMD_STOP;
        r.aborted = 1'b1;
        seq_ph = PH_STOP;
      end
      // the stop completion event returns the sequencer to ready
      if (r.bus_command == CMD_NONE && seq_ph == PH_STOP) seq_ph = PH_READY;
    end
    r.idle = (seq_ph == PH_READY);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued items on in_, record each one at its handshake
  // --------------------------------------------------------------------------
  in_item_t cur_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // step the local sequencer in the order the block takes the items
      if (in_tvalid && in_tready) begin
        expected_steps.push_back(next_bus_step(cur_item));
        accepted_count++;
      end
      // load the next item only once the current one is gone; hold otherwise
      if (!in_tvalid || in_tready) begin
        if (sequencer_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = sequencer_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, cur_item.rx_byte, cur_item.ack_received};
          in_tuser <= cur_item.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare every result taken on out_ with the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  int hold_taken = 0;
  int hold_left = 0;

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual 0x%0h last %0b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = expected_steps.pop_front();
        check_field("bus_command", want.bus_command, out_tdata[2:0]);
        check_field("tx_byte",     want.tx_byte,     out_tdata[10:3]);
        check_field("ack_level",   want.ack_level,   out_tdata[11]);
        check_field("word_valid",  want.word_valid,  out_tdata[12]);
        check_field("word_index",  want.word_index,  out_tdata[17:13]);
        check_field("word_value",  want.word_value,  out_tdata[33:18]);
        check_field("burst_done",  want.burst_done,  out_tlast);
        check_field("aborted",     want.aborted,     out_tdata[34]);
        check_field("idle",        want.idle,        out_tdata[35]);
      end
    end
    // start a long hold-off when asked; random stalls otherwise
    if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no channel moves for too long
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("i2c_burst_read_sequencer_unit regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_item(logic mode, logic ack, logic [7:0] rx);
    in_item_t it;
    it.mode = mode;
    it.ack_received = ack;
    it.rx_byte = rx;
    sequencer_items.push_back(it);
    issued_count++;
  endfunction

  // Now and then drop in a start request that arrives while the block is busy.
  function automatic void stray_start();
    if ($urandom_range(0, 19) == 0)
      queue_item(MODE_START, 1'($urandom), 8'($urandom));
  endfunction

  // Queue one read sequence: mostly full bursts with random data, some cut off
  // by a NACK on one of the three address bytes. Returns the items that move
  // the sequencer, stray ones left out.
  function automatic int queue_burst();
    int nack_at;
    int n;
    nack_at = $urandom_range(0, 9);  // 0..2 pick an abort point, else full burst
    n = 0;
    // an event with nothing going on is dropped
    if ($urandom_range(0, 5) == 0) queue_item(MODE_EVENT, 1'($urandom), 8'($urandom));
    queue_item(MODE_START, 1'($urandom), 8'($urandom));
    stray_start();
    queue_item(MODE_EVENT, 1'($urandom), 8'($urandom));
    stray_start();
    queue_item(MODE_EVENT, nack_at != 0, 8'($urandom));
    n += 3;
    if (nack_at != 0) begin
      stray_start();
      queue_item(MODE_EVENT, nack_at != 1, 8'($urandom));
      n++;
      if (nack_at != 1) begin
        stray_start();
        queue_item(MODE_EVENT, 1'($urandom), 8'($urandom));
        stray_start();
        queue_item(MODE_EVENT, nack_at != 2, 8'($urandom));
        n += 2;
        if (nack_at != 2) begin
          // receive / ack bit pairs, ack on the receive is don't-care
          for (int k = 0; k < BURST_BYTES; k++) begin
            queue_item(MODE_EVENT, 1'($urandom), 8'($urandom));
            stray_start();
            queue_item(MODE_EVENT, 1'($urandom), 8'($urandom));
            n += 2;
          end
        end
      end
    end
    // stop completion
    queue_item(MODE_EVENT, 1'($urandom), 8'($urandom));
    return n + 1;
  endfunction

  // Hold off new items until everything sent has come back, then let the
  // pipeline settle.
  task automatic wait_quiet();
    do @(posedge clk); while (accepted_count != issued_count || expected_steps.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WADDR: cfg_waddr = val;
      CFG_RADDR: cfg_raddr = val;
      CFG_FIRST: cfg_first = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int moved;
    moved = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset configuration, slow receiver
    queue_item(MODE_EVENT, 1'b1, 8'hFF);   // event while ready is dropped
    queue_item(MODE_START, 1'b0, 8'h00);
    queue_item(MODE_START, 1'b1, 8'hFF);   // start while busy is dropped
    queue_item(MODE_EVENT, 1'b0, 8'h00);   // send write address
    queue_item(MODE_EVENT, 1'b0, 8'hFF);   // NACK on the write address
    queue_item(MODE_EVENT, 1'b1, 8'h00);   // stop done
    queue_item(MODE_START, 1'b1, 8'hFF);
    queue_item(MODE_EVENT, 1'b1, 8'h00);
    queue_item(MODE_EVENT, 1'b1, 8'hFF);
    queue_item(MODE_EVENT, 1'b0, 8'h00);   // NACK on the register pointer
    queue_item(MODE_EVENT, 1'b0, 8'hFF);
    queue_item(MODE_START, 1'b0, 8'h00);
    queue_item(MODE_EVENT, 1'b0, 8'hFF);
    queue_item(MODE_EVENT, 1'b1, 8'h00);
    queue_item(MODE_EVENT, 1'b1, 8'hFF);
    queue_item(MODE_EVENT, 1'b0, 8'h00);   // restart done, send read address
    queue_item(MODE_EVENT, 1'b0, 8'hFF);   // NACK on the read address
    queue_item(MODE_EVENT, 1'b1, 8'h00);
    queue_item(MODE_EVENT, 1'b0, 8'h00);   // back in ready, dropped
    moved = issued_count;
    wait_quiet();

    // Phase 1: all-ones configuration, slow receiver
    write_reg(CFG_WADDR, 8'hFF);
    write_reg(CFG_RADDR, 8'hFF);
    write_reg(CFG_FIRST, 8'hFF);
    send_idle_pct = 29;
    recv_idle_pct = 76;
    while (moved < 330) moved += queue_burst();
    wait_quiet();

    // Phase 2: all-zeros configuration, slow sender
    write_reg(CFG_WADDR, 8'h00);
    write_reg(CFG_RADDR, 8'h00);
    write_reg(CFG_FIRST, 8'h00);
    send_idle_pct = 76;
    recv_idle_pct = 29;
    while (moved < 640) moved += queue_burst();
    wait_quiet();

    // Phase 3: random configuration, no idling; the receiver first holds off
    // for a long stretch while items keep coming, so the input backs up
    write_reg(CFG_FIRST, 8'($urandom));
    write_reg(CFG_WADDR, 8'($urandom));
    write_reg(CFG_RADDR, 8'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (moved < 950) moved += queue_burst();
    hold_req++;
    wait_quiet();

    if (mismatches == 0) begin
      $display("i2c_burst_read_sequencer_unit regression: pass");
    end else begin
      $display("i2c_burst_read_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/ibrs_pkg.sv
sv/ibrs_cfg_regs.sv
sv/ibrs_seq.sv
sv/i2c_burst_read_sequencer_unit.sv
sv/ibrs_checker.sv
test/tb_i2c_burst_read_sequencer_unit.sv
